// ===== hw/rtl/mbe_pkg.sv =====
// Shared types, widths and constants of the Mandelbrot escape-time block.
// Used by mbe_stream_if.sv and mandelbrot_escape_time.sv; depends on nothing.
package mbe_pkg;

	localparam int DATA_W    = 32;              // Q4.28 coordinate width
	localparam int FRAC_BITS = 28;              // fraction bits of a coordinate
	localparam int COUNT_W   = 16;              // iteration count width
	localparam int PROD_W    = 2 * DATA_W;      // exact product width (Q8.56)
	localparam int SUM_W     = PROD_W - FRAC_BITS + 4; // wide z update, never wraps

	localparam int REG_IDX_W = 1;
	localparam int ADDR_W    = REG_IDX_W + 2;   // byte address of 32-bit registers
	localparam int APB_W     = 32;

	localparam logic [REG_IDX_W-1:0] REG_MAX_ITER = '0;
	localparam logic [COUNT_W-1:0]   MAX_ITER_RST = COUNT_W'(256);

	// 4.0 at Q8.56
	localparam logic [PROD_W-1:0] FOUR_Q = PROD_W'(1) << (2 * FRAC_BITS + 2);

	typedef struct packed {
		logic signed [DATA_W-1:0] c_real;
		logic signed [DATA_W-1:0] c_imag;
		logic                     last_pixel;
	} point_t;

	typedef struct packed {
		logic [COUNT_W-1:0] iter_count;
		logic               in_set;
		logic               last_pixel_res;
	} result_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL_XY,
		S_ADD,
		S_MUL_XX,
		S_MUL_YY,
		S_CMP,
		S_DONE
	} state_t;

endpackage

// ===== hw/rtl/mbe_stream_if.sv =====
// Valid/ready channels for point items and result items.
// Depends on mbe_pkg for the payload types.
interface mbe_pt_if;
	logic            valid;
	logic            ready;
	mbe_pkg::point_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface mbe_res_if;
	logic             valid;
	logic             ready;
	mbe_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/mandelbrot_escape_time.sv =====
// Mandelbrot escape-time unit: one 32x32 multiplier shared under a sequencer.
// Each z update steps through S_MUL_XY, S_ADD, S_MUL_XX, S_MUL_YY and S_CMP; S_IDLE accepts
// the point and S_DONE loads the result. An update that leaves the Q4.28 range ends the point
// straight from S_ADD. One point at a time: a new point is taken only in S_IDLE, after the last
// result has been loaded; the single multiplier serves S_MUL_XY, S_MUL_XX and S_MUL_YY.
// Reset (arst_n low, asynchronous): sequencer idle, result empty, max_iter = 256.
module mandelbrot_escape_time (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mbe_pkg::ADDR_W-1:0]   paddr,
	input  logic [mbe_pkg::APB_W-1:0]    pwdata,
	output logic [mbe_pkg::APB_W-1:0]    prdata,
	output logic                         pready,
	mbe_pt_if.sink                       pt,
	mbe_res_if.source                    res
);

	localparam int DW = mbe_pkg::DATA_W;
	localparam int PW = mbe_pkg::PROD_W;
	localparam int SW = mbe_pkg::SUM_W;
	localparam int CW = mbe_pkg::COUNT_W;

	// Sequencer
	mbe_pkg::state_t state_q, state_d;

	// Configuration
	logic [CW-1:0] max_iter_q;
	logic          cfg_wr;
	logic [mbe_pkg::REG_IDX_W-1:0] cfg_idx;

	// Point and iterate
	logic signed [DW-1:0] cr_q, ci_q, zr_q, zi_q;
	logic                 last_q;
	logic [CW-1:0]        cnt_q;
	logic                 in_set_q;

	// Products: xx/yy are x^2 and y^2 of the current z; they double as |z|^2 terms
	logic signed [PW-1:0] xx_q, yy_q, xy_q, diff_q;

	// Shared multiplier
	logic signed [DW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] prod;

	// Update and compare
	logic signed [SW-1:0] nr_w, ni_w;
	logic                 step_fits;
	logic [PW-1:0]        mag_sq;
	logic                 mag_esc;
	logic [CW-1:0]        cnt_inc;
	logic                 accept;
	logic                 load_res;

	// Result register
	logic                 res_valid_q;
	mbe_pkg::result_t     res_q;

	// ---------------------------------------------------------------------
	// APB register: max_iter at register index 0, written on the access phase
	// ---------------------------------------------------------------------
	assign pready  = 1'b1;
	assign cfg_idx = paddr[mbe_pkg::ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite;
	assign prdata  = (cfg_idx == mbe_pkg::REG_MAX_ITER) ? mbe_pkg::APB_W'(max_iter_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q <= mbe_pkg::MAX_ITER_RST;
		end else if (cfg_wr && cfg_idx == mbe_pkg::REG_MAX_ITER) begin
			max_iter_q <= pwdata[CW-1:0];
		end
	end

	// ---------------------------------------------------------------------
	// Shared multiplier: operand pair picked by the sequencer step
	// ---------------------------------------------------------------------
	always_comb begin
		unique case (state_q)
			mbe_pkg::S_MUL_XX: begin
				mul_a = zr_q;
				mul_b = zr_q;
			end
			mbe_pkg::S_MUL_YY: begin
				mul_a = zi_q;
				mul_b = zi_q;
			end
			default: begin
				mul_a = zr_q;
				mul_b = zi_q;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// ---------------------------------------------------------------------
	// z update at wide precision. Floor rounding is the arithmetic shift.
	// x*y is shifted one bit less, which folds in the factor of two.
	// A value outside Q4.28 means |z| >= 8: count it as an escape at once.
	// ---------------------------------------------------------------------
	assign nr_w = SW'(diff_q >>> mbe_pkg::FRAC_BITS) + SW'(cr_q);
	assign ni_w = SW'(xy_q >>> (mbe_pkg::FRAC_BITS - 1)) + SW'(ci_q);

	assign step_fits = (nr_w == SW'($signed(nr_w[DW-1:0])))
	                && (ni_w == SW'($signed(ni_w[DW-1:0])));

	// Both squares are nonnegative and at most 2^62, so the sum cannot wrap
	assign mag_sq  = $unsigned(xx_q) + $unsigned(yy_q);
	assign mag_esc = mag_sq > mbe_pkg::FOUR_Q;
	assign cnt_inc = cnt_q + CW'(1);

	// ---------------------------------------------------------------------
	// Sequencer: next state and handshake strobes
	// ---------------------------------------------------------------------
	assign accept = pt.valid && pt.ready;

	always_comb begin
		state_d  = state_q;
		pt.ready = 1'b0;
		load_res = 1'b0;
		unique case (state_q)
			mbe_pkg::S_IDLE: begin
				pt.ready = 1'b1;
				if (pt.valid) begin
					// zero max_iter: report in set without any update
					state_d = (max_iter_q == '0) ? mbe_pkg::S_DONE : mbe_pkg::S_MUL_XY;
				end
			end
			mbe_pkg::S_MUL_XY: begin
				state_d = mbe_pkg::S_ADD;
			end
			mbe_pkg::S_ADD: begin
				state_d = step_fits ? mbe_pkg::S_MUL_XX : mbe_pkg::S_DONE;
			end
			mbe_pkg::S_MUL_XX: begin
				state_d = mbe_pkg::S_MUL_YY;
			end
			mbe_pkg::S_MUL_YY: begin
				state_d = mbe_pkg::S_CMP;
			end
			mbe_pkg::S_CMP: begin
				if (mag_esc || cnt_inc == max_iter_q) begin
					state_d = mbe_pkg::S_DONE;
				end else begin
					state_d = mbe_pkg::S_MUL_XY;
				end
			end
			mbe_pkg::S_DONE: begin
				// hold until the result register is free or being drained
				if (!res_valid_q || res.ready) begin
					load_res = 1'b1;
					state_d  = mbe_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = mbe_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mbe_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ---------------------------------------------------------------------
	// Datapath registers, advanced one step per sequencer state
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		unique case (state_q)
			mbe_pkg::S_IDLE: begin
				if (accept) begin
					cr_q     <= pt.data.c_real;
					ci_q     <= pt.data.c_imag;
					last_q   <= pt.data.last_pixel;
					zr_q     <= '0;
					zi_q     <= '0;
					xx_q     <= '0;
					yy_q     <= '0;
					cnt_q    <= '0;
					in_set_q <= (max_iter_q == '0);
				end
			end
			mbe_pkg::S_MUL_XY: begin
				xy_q   <= prod;
				diff_q <= xx_q - yy_q;
			end
			mbe_pkg::S_ADD: begin
				zr_q <= nr_w[DW-1:0];
				zi_q <= ni_w[DW-1:0];
			end
			mbe_pkg::S_MUL_XX: begin
				xx_q <= prod;
			end
			mbe_pkg::S_MUL_YY: begin
				yy_q <= prod;
			end
			mbe_pkg::S_CMP: begin
				if (!mag_esc) begin
					cnt_q <= cnt_inc;
					if (cnt_inc == max_iter_q) begin
						in_set_q <= 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// ---------------------------------------------------------------------
	// Result register: parts the sequencer from the result channel
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_res) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_q.iter_count     <= in_set_q ? '0 : cnt_q;
			res_q.in_set         <= in_set_q;
			res_q.last_pixel_res <= last_q;
		end
	end

	assign res.valid = res_valid_q;
	assign res.data  = res_q;

	// ---------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------
	a_cnt_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mbe_pkg::S_MUL_XY || state_q == mbe_pkg::S_ADD
		 || state_q == mbe_pkg::S_MUL_XX || state_q == mbe_pkg::S_MUL_YY
		 || state_q == mbe_pkg::S_CMP) |-> (cnt_q < max_iter_q))
		else $error("iteration count reached max_iter while still iterating");

	a_squares_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mbe_pkg::S_CMP) |-> (!xx_q[PW-1] && !yy_q[PW-1]))
		else $error("magnitude terms are not squares");

	a_in_set_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.data.in_set) |-> (res.data.iter_count == '0))
		else $error("in-set result carries a nonzero count");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res.ready) |-> !load_res)
		else $error("result overwritten before it was taken");

endmodule

// ===== dv/tb_mandelbrot_escape_time.sv =====
// Testbench for mandelbrot_escape_time: streams points in, predicts each escape count,
// and checks every result item. Depends on mbe_pkg and the channels in mbe_stream_if.sv.
`timescale 1ns / 1ps

module tb_mandelbrot_escape_time;

	localparam int HALF_PERIOD = 10;
	localparam int LIMIT_NS    = 100_000_000;     // several times the slowest correct run

	// Q4.28 coordinates used by the directed points
	localparam logic [mbe_pkg::DATA_W-1:0] C_ZERO    = 32'h0000_0000;
	localparam logic [mbe_pkg::DATA_W-1:0] C_TWO     = 32'h2000_0000;   //  2.0
	localparam logic [mbe_pkg::DATA_W-1:0] C_NEG_TWO = 32'hE000_0000;   // -2.0
	localparam logic [mbe_pkg::DATA_W-1:0] C_MAX     = 32'h7FFF_FFFF;
	localparam logic [mbe_pkg::DATA_W-1:0] C_MIN     = 32'h8000_0000;
	localparam logic [mbe_pkg::DATA_W-1:0] C_QUARTER = 32'h0400_0000;   //  0.25, cusp
	localparam logic [mbe_pkg::DATA_W-1:0] C_026     = 32'd69793219;    //  0.26, slow escape
	localparam logic [mbe_pkg::DATA_W-1:0] C_NEG_075 = 32'hF400_0000;   // -0.75, neck
	localparam logic [mbe_pkg::DATA_W-1:0] C_TENTH   = 32'd26843546;    //  0.1

	localparam logic [mbe_pkg::ADDR_W-1:0] MAX_ITER_ADDR = {mbe_pkg::REG_MAX_ITER, 2'b00};
	localparam longint Z_SPAN = 64'sd1 <<< (mbe_pkg::DATA_W - 1);

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [mbe_pkg::ADDR_W-1:0] paddr;
	logic [mbe_pkg::APB_W-1:0]  pwdata;
	logic [mbe_pkg::APB_W-1:0]  prdata;
	logic                       pready;

	mbe_pt_if  pt_ch ();
	mbe_res_if res_ch ();

	mandelbrot_escape_time dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pt      (pt_ch),
		.res     (res_ch)
	);

	// Mirror of max_iter, expected result items in order, and run statistics
	logic [mbe_pkg::COUNT_W-1:0] iter_limit = mbe_pkg::MAX_ITER_RST;
	mbe_pkg::result_t            pending_results[$];
	int                          errors      = 0;
	int                          n_results   = 0;
	int                          n_in_set    = 0;
	int                          n_escaped   = 0;
	int                          n_settings  = 0;

	// Idle rate shared by sender and receiver, and the receiver hold-off request
	int idle_pct  = 8;
	bit hold_go   = 1'b0;
	int hold_len  = 0;

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// Escape-time predictor: iterate z <- z^2 + c at double width from z = 0.
	// Products are exact; the shifts round toward minus infinity. A z outside the
	// 32-bit range counts as an escape without squaring.
	function automatic mbe_pkg::result_t escape_time(mbe_pkg::point_t pt_in,
			logic [mbe_pkg::COUNT_W-1:0] limit);
		longint                      cr;
		longint                      ci;
		longint                      zr;
		longint                      zi;
		longint                      nr;
		longint                      ni;
		longint unsigned             mag;
		logic [mbe_pkg::COUNT_W-1:0] steps;
		bit                          escaped;
		mbe_pkg::result_t            r;
		cr      = longint'($signed(pt_in.c_real));
		ci      = longint'($signed(pt_in.c_imag));
		zr      = 0;
		zi      = 0;
		steps   = '0;
		escaped = 1'b0;
		while (!escaped && steps < limit) begin
			nr = ((zr * zr - zi * zi) >>> mbe_pkg::FRAC_BITS) + cr;
			ni = ((zr * zi) >>> (mbe_pkg::FRAC_BITS - 1)) + ci;
			if (nr < -Z_SPAN || nr >= Z_SPAN || ni < -Z_SPAN || ni >= Z_SPAN) begin
				escaped = 1'b1;
			end else begin
				mag = nr * nr;
				mag = mag + ni * ni;
				if (mag > mbe_pkg::FOUR_Q) begin
					escaped = 1'b1;
				end else begin
					steps = steps + 1'b1;
					zr    = nr;
					zi    = ni;
				end
			end
		end
		r.iter_count     = escaped ? steps : '0;
		r.in_set         = !escaped;
		r.last_pixel_res = pt_in.last_pixel;
		return r;
	endfunction

	function automatic mbe_pkg::point_t make_point(logic [mbe_pkg::DATA_W-1:0] re,
			logic [mbe_pkg::DATA_W-1:0] im, logic last);
		mbe_pkg::point_t p;
		p.c_real     = re;
		p.c_imag     = im;
		p.last_pixel = last;
		return p;
	endfunction

	// Pick a coordinate from the corners and axis crossings of the fixed-point range
	function automatic logic [mbe_pkg::DATA_W-1:0] edge_coord();
		case ($urandom_range(5))
			0:       return C_ZERO;
			1:       return C_TWO;
			2:       return C_NEG_TWO;
			3:       return C_MAX;
			4:       return C_MIN;
			default: return C_TWO + 1'b1;
		endcase
	endfunction

	// Most points fall in the box around the set, where iteration runs deep; the rest are
	// edge coordinates or full-range noise that mostly escapes at once.
	function automatic mbe_pkg::point_t random_point(int inner_pct);
		mbe_pkg::point_t p;
		int              pick;
		pick = $urandom_range(99);
		if (pick < inner_pct) begin
			p.c_real = $urandom_range(32'd671088640) - 32'd536870912;  // -2.0 .. 0.5
			p.c_imag = $urandom_range(32'd671088640) - 32'd335544320;  // -1.25 .. 1.25
		end else if (pick < inner_pct + 5) begin
			p.c_real = edge_coord();
			p.c_imag = edge_coord();
		end else begin
			p.c_real = $urandom;
			p.c_imag = $urandom;
		end
		p.last_pixel = $urandom_range(1);
		return p;
	endfunction

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// Offer one point, idling at random first; record its prediction at acceptance.
	// Leave valid high afterward so back-to-back items need no extra assignment.
	task automatic send_point(mbe_pkg::point_t p);
		while ($urandom_range(99) < idle_pct) begin
			pt_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pt_ch.valid <= 1'b1;
		pt_ch.data  <= p;
		do @(posedge clk); while (!pt_ch.ready);
		pending_results.push_back(escape_time(p, iter_limit));
	endtask

	// Drop valid and hold until every expected result item has arrived
	task automatic finish_phase();
		pt_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic apb_write(logic [mbe_pkg::ADDR_W-1:0] addr,
			logic [mbe_pkg::APB_W-1:0] word);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_read(logic [mbe_pkg::ADDR_W-1:0] addr,
			output logic [mbe_pkg::APB_W-1:0] word);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		word     = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Write max_iter (upper bits of the word are don't-care), read it back, update mirror
	task automatic set_limit(logic [mbe_pkg::APB_W-1:0] word);
		logic [mbe_pkg::APB_W-1:0] rd;
		apb_write(MAX_ITER_ADDR, word);
		apb_read(MAX_ITER_ADDR, rd);
		check_field("max_iter readback", word[mbe_pkg::COUNT_W-1:0],
			rd[mbe_pkg::COUNT_W-1:0]);
		iter_limit = word[mbe_pkg::COUNT_W-1:0];
		n_settings++;
	endtask

	// Reset value of max_iter, then boundary points: the strict |z|^2 > 4 test on both
	// axes, range corners, the cusp and neck of the set, and both marker values.
	task automatic test_reset_default();
		logic [mbe_pkg::APB_W-1:0] rd;
		apb_read(MAX_ITER_ADDR, rd);
		check_field("max_iter after reset", mbe_pkg::MAX_ITER_RST,
			rd[mbe_pkg::COUNT_W-1:0]);
		n_settings++;
		send_point(make_point(C_ZERO, C_ZERO, 1'b0));
		send_point(make_point(C_NEG_TWO, C_ZERO, 1'b1));   // settles at z = 2, never escapes
		send_point(make_point(C_TWO, C_ZERO, 1'b0));       // |z|^2 == 4 once, then out
		send_point(make_point(C_TWO + 1'b1, C_ZERO, 1'b1));
		send_point(make_point(C_ZERO, C_TWO, 1'b0));
		send_point(make_point(C_ZERO, C_NEG_TWO, 1'b1));
		send_point(make_point(C_MAX, C_MAX, 1'b1));
		send_point(make_point(C_MIN, C_MIN, 1'b0));
		send_point(make_point(C_MIN, C_MAX, 1'b1));
		send_point(make_point(C_026, C_ZERO, 1'b0));
		send_point(make_point(C_NEG_075, C_TENTH, 1'b1));
		send_point(make_point(C_QUARTER, C_ZERO, 1'b0));
		finish_phase();
	endtask

	// max_iter of zero: no update at all, everything reports in set
	task automatic test_zero_limit();
		set_limit(32'h0000_0000);
		send_point(make_point(C_ZERO, C_ZERO, 1'b1));
		send_point(make_point(C_MAX, C_MIN, 1'b0));
		send_point(make_point(C_TWO + 1'b1, C_ZERO, 1'b1));
		finish_phase();
	endtask

	// One update: escape on the first step versus surviving exactly one
	task automatic test_single_step();
		set_limit(32'h0000_0001);
		send_point(make_point(C_ZERO, C_ZERO, 1'b0));
		send_point(make_point(C_TWO + 1'b1, C_ZERO, 1'b1));
		send_point(make_point(C_TWO, C_ZERO, 1'b0));
		send_point(make_point(C_MIN, C_ZERO, 1'b1));
		finish_phase();
	endtask

	// Largest max_iter, written with the upper bus bits set; one point runs the counter
	// all the way to 0xFFFF
	task automatic test_full_limit();
		set_limit(32'hFFFF_FFFF);
		send_point(make_point(C_026, C_ZERO, 1'b1));
		send_point(make_point(C_MAX, C_MIN, 1'b0));
		send_point(make_point(C_ZERO, C_ZERO, 1'b1));
		finish_phase();
	endtask

	// Random points over several max_iter settings; one phase runs without idling
	task automatic test_random_sweep();
		int phase;
		int i;
		set_limit({16'($urandom), 16'd256});
		for (i = 0; i < 200; i++)
			send_point(random_point(75));
		finish_phase();
		for (phase = 0; phase < 5; phase++) begin
			set_limit({16'($urandom), 16'($urandom_range(40, 2))});
			idle_pct = (phase == 2) ? 0 : 8;
			for (i = 0; i < 200; i++)
				send_point(random_point(80));
			finish_phase();
		end
		idle_pct = 8;
	endtask

	// Hold the result side off for long stretches while points keep coming, so the
	// block fills and stalls its input
	task automatic test_backpressure();
		int i;
		set_limit(32'd8);
		hold_len = 2000;
		hold_go  = 1'b1;
		for (i = 0; i < 150; i++) begin
			if (i == 75) begin
				hold_len = 500;
				hold_go  = 1'b1;
			end
			send_point(random_point(80));
		end
		finish_phase();
	endtask

	// Result side: compare each accepted item with the oldest prediction, then choose
	// ready for the next cycle (hold-off first, else random idling)
	initial begin : result_monitor
		mbe_pkg::result_t want;
		int               hold_left;
		hold_left    = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_ch.valid && res_ch.ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result item: expected none, actual %0d/%0b/%0b",
						$time, res_ch.data.iter_count, res_ch.data.in_set,
						res_ch.data.last_pixel_res);
					errors++;
				end else begin
					want = pending_results.pop_front();
					check_field("iter_count", want.iter_count, res_ch.data.iter_count);
					check_field("in_set", want.in_set, res_ch.data.in_set);
					check_field("last_pixel_res", want.last_pixel_res,
						res_ch.data.last_pixel_res);
					n_results++;
					if (want.in_set)
						n_in_set++;
					else
						n_escaped++;
				end
			end
			if (hold_go) begin
				hold_left = hold_len;
				hold_go   = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= idle_pct);
			end
		end
	end

	initial begin
		arst_n      = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		pt_ch.valid = 1'b0;
		pt_ch.data  = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_default();
		test_zero_limit();
		test_single_step();
		test_full_limit();
		test_random_sweep();
		test_backpressure();

		// Let any stray result item show up before the verdict
		repeat (64) @(posedge clk);
		$display("Checked %0d result items (%0d in set, %0d escaped) across %0d max_iter",
			n_results, n_in_set, n_escaped, n_settings);
		$display("settings from 0 to 65535, with random idling and long result hold-offs.");
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin : run_limit
		#LIMIT_NS;
		$display("%0t: timeout with %0d result items outstanding", $time,
			pending_results.size());
		$display("TEST FAILED");
		$finish;
	end

endmodule
